### src/lgs_pkg.sv
package lgs_pkg;

  // configuration port
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

  // grid size defaults and limits
  localparam int unsigned GRID_RESET     = 100;
  localparam int unsigned MIN_SIZE       = 3;
  localparam int unsigned MAX_WIDTH_DEF  = 128;
  localparam int unsigned MAX_HEIGHT_DEF = 128;

  // result position fields
  localparam int unsigned POS_W = 7;

  // 3x3 window, columns oldest to newest from the lsb, center at bit 4
  localparam int unsigned WIN_W      = 9;
  localparam int unsigned WIN_CENTER = 4;

  // rule B3/S23
  localparam int unsigned BIRTH_COUNT   = 3;
  localparam int unsigned SURVIVE_COUNT = 2;

  typedef struct packed {
    logic             next_alive;
    logic [POS_W-1:0] out_row;
    logic [POS_W-1:0] out_col;
    logic             frame_last;
  } result_t;

  // clamp a programmed size into [MIN_SIZE, hi]
  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    int unsigned r;
    r = v;
    if (v < MIN_SIZE) begin
      r = MIN_SIZE;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  // next state of the center cell from its 3x3 neighborhood
  function automatic logic life_rule(logic [WIN_W-1:0] win);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      if (i != WIN_CENTER) begin
        n = n + {3'b000, win[i]};
      end
    end
    return (n == 4'(BIRTH_COUNT)) || (win[WIN_CENTER] && (n == 4'(SURVIVE_COUNT)));
  endfunction

endpackage

### src/lgs_in_if.sv
interface lgs_in_if;
  logic valid;
  logic ready;
  logic action;
  logic alive;

  modport source (output valid, output action, output alive, input ready);
  modport sink   (input valid, input action, input alive, output ready);
endinterface

### src/lgs_out_if.sv
interface lgs_out_if;
  logic                     valid;
  logic                     ready;
  logic                     next_alive;
  logic [lgs_pkg::POS_W-1:0] out_row;
  logic [lgs_pkg::POS_W-1:0] out_col;
  logic                     frame_last;

  modport source (output valid, output next_alive, output out_row, output out_col,
                  output frame_last, input ready);
  modport sink   (input valid, input next_alive, input out_row, input out_col,
                  input frame_last, output ready);
endinterface

### src/life_generation_stencil_unit.sv
// Conway Life generation unit, rule B3/S23.
// cell_i takes one beat per cell of the current generation in raster order
// (row 0 first, columns upward); action=1 marks a dead padding beat. After the
// last cell, grid_width+1 padding beats drain the remaining results.
// result_o gives zero or one beat per input beat: the next state of a cell, its
// row and column, and frame_last on the final cell of the grid.
// A cell's result is produced on the input beat one row below and one column to
// its right; it is valid on the cycle after that beat unless result_o stalls.
// Throughput is one cell per cycle: the two line buffers share one memory that
// is written and read ahead once per cycle, and the window is a 9-bit register.
// A two-entry output buffer lets input beats continue while result_o stalls;
// cell_i.ready falls only when both entries hold a beat.
// Configuration: cfg_we_i writes grid_width (index 0) or grid_height (index 1)
// and restarts the raster position at row 0, column 0; sizes clamp to the
// range 3 to the maximum. Write only while idle.
// Reset (rst_ni, asynchronous) returns the sizes to 100 and the position to
// the origin; no memory clearing pass is needed.
module life_generation_stencil_unit #(
  parameter int unsigned MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lgs_in_if.sink                         cell_i,
  lgs_out_if.source                      result_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0]    width;
  logic [HW-1:0]    height;
  logic             restart, accept, res_valid, buf_ready;
  lgs_pkg::result_t res;

  assign cell_i.ready = buf_ready;
  assign accept       = cell_i.valid && buf_ready;

  // size registers
  lgs_cfg #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .width_o     (width),
    .height_o    (height),
    .restart_o   (restart)
  );

  // line buffers, window and rule
  lgs_stencil #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_stencil (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .width_i     (width),
    .height_i    (height),
    .accept_i    (accept),
    .action_i    (cell_i.action),
    .alive_i     (cell_i.alive),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result buffering
  lgs_out_skid u_out_skid (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .data_i  (res),
    .ready_o (buf_ready),
    .out_o   (result_o)
  );

endmodule

### src/lgs_cfg.sv
module lgs_cfg #(
  parameter int unsigned MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [lgs_pkg::CFG_DATA_W-1:0]        cfg_wdata_i,
  output logic [$clog2(MAX_WIDTH+1)-1:0]        width_o,
  output logic [$clog2(MAX_HEIGHT+1)-1:0]       height_o,
  output logic                                  restart_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;

  // sizes are stored already clamped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(lgs_pkg::clamp_size(lgs_pkg::GRID_RESET, MAX_WIDTH));
      height_q <= HW'(lgs_pkg::clamp_size(lgs_pkg::GRID_RESET, MAX_HEIGHT));
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lgs_pkg::CFG_GRID_WIDTH: begin
          width_q <= WW'(lgs_pkg::clamp_size(32'(cfg_wdata_i), MAX_WIDTH));
        end
        lgs_pkg::CFG_GRID_HEIGHT: begin
          height_q <= HW'(lgs_pkg::clamp_size(32'(cfg_wdata_i), MAX_HEIGHT));
        end
        default: begin
        end
      endcase
    end
  end

  // a grid_width or grid_height write restarts the raster position
  assign restart_o = cfg_we_i && ((cfg_idx_i == lgs_pkg::CFG_GRID_WIDTH) ||
                                  (cfg_idx_i == lgs_pkg::CFG_GRID_HEIGHT));
  assign width_o   = width_q;
  assign height_o  = height_q;

endmodule

### src/lgs_stencil.sv
module lgs_stencil #(
  parameter int unsigned MAX_WIDTH  = lgs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = lgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            restart_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]  width_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0] height_i,
  input  logic                            accept_i,
  input  logic                            action_i,
  input  logic                            alive_i,
  output logic                            res_valid_o,
  output lgs_pkg::result_t                res_o
);

  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT + 2);
  localparam int unsigned WIN_W = lgs_pkg::WIN_W;

  logic [COL_W-1:0] col_q, col_d, col_nx, ec;
  logic [ROW_W-1:0] row_q, row_d, row_nx, er, h_ext;
  logic [WIN_W-1:0] win_q, win_d, win_shift, win;
  logic [1:0]       line_mem [MAX_WIDTH];
  logic [1:0]       rd_q;
  logic [1:0]       wr_data;
  logic             cur_cell, top, mid, valid, last;
  logic [2:0]       col_bits;

  assign h_ext = ROW_W'(height_i);

  // new column of the window: two rows from the line buffers, one from the input
  always_comb begin
    cur_cell = (!action_i && (row_q < h_ext)) ? alive_i : 1'b0;
    top      = (row_q >= ROW_W'(2)) ? rd_q[1] : 1'b0;
    mid      = (row_q >= ROW_W'(1)) ? rd_q[0] : 1'b0;
    col_bits = {cur_cell, mid, top};
    wr_data  = {rd_q[0], cur_cell};
  end

  // window shift and position of the cell that is complete now
  always_comb begin
    if (col_q == '0) begin
      // row start: the last cell of the row before gets a dead right column
      win       = {3'b000, win_q[WIN_W-1:3]};
      win_shift = {col_bits, 6'b000000};
      valid     = row_q >= ROW_W'(2);
      er        = row_q - ROW_W'(2);
      ec        = COL_W'(width_i - WW'(1));
    end else begin
      win_shift = {col_bits, win_q[WIN_W-1:3]};
      win       = win_shift;
      valid     = row_q >= ROW_W'(1);
      er        = row_q - ROW_W'(1);
      ec        = col_q - COL_W'(1);
    end
    if (er >= h_ext) begin
      valid = 1'b0;
    end
    last = (er == h_ext - ROW_W'(1)) && (ec == COL_W'(width_i - WW'(1)));
  end

  // raster position advance
  always_comb begin
    if (WW'(col_q) + WW'(1) == width_i) begin
      col_nx = '0;
      row_nx = row_q + ROW_W'(1);
    end else begin
      col_nx = col_q + COL_W'(1);
      row_nx = row_q;
    end
    col_d = col_q;
    row_d = row_q;
    win_d = win_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (accept_i) begin
      win_d = win_shift;
      if (valid && last) begin
        col_d = '0;
        row_d = '0;
      end else begin
        col_d = col_nx;
        row_d = row_nx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      win_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      win_q <= win_d;
    end
  end

  // line buffers packed as {two above, above}; read ahead at the next column
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      line_mem[col_q] <= wr_data;
    end
    rd_q <= line_mem[col_d];
  end

  assign res_valid_o      = accept_i && valid;
  assign res_o.next_alive = lgs_pkg::life_rule(win);
  assign res_o.out_row    = lgs_pkg::POS_W'(er);
  assign res_o.out_col    = lgs_pkg::POS_W'(ec);
  assign res_o.frame_last = last;

`ifndef ASSERT_OFF
  a_col_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    WW'(col_q) < width_i)
    else $error("column position beyond grid width");

  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= h_ext + ROW_W'(1))
    else $error("row position beyond flush rows");

  a_last_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.frame_last |=> (col_q == '0) && (row_q == '0))
    else $error("position not back at origin after last cell");

  a_first_row_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && (row_q == '0) |-> !res_valid_o)
    else $error("result emitted while first row fills");
`endif

endmodule

### src/lgs_out_skid.sv
module lgs_out_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  lgs_pkg::result_t data_i,
  output logic             ready_o,
  lgs_out_if.source        out_o
);

  lgs_pkg::result_t out_q, skid_q;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  logic             load_out, load_skid, out_from_skid, pop;

  assign pop = out_valid_q && out_o.ready;

  // two-entry output buffer: output register plus skid register
  always_comb begin
    out_valid_d   = out_valid_q;
    skid_valid_d  = skid_valid_q;
    load_out      = 1'b0;
    load_skid     = 1'b0;
    out_from_skid = 1'b0;
    if (skid_valid_q) begin
      if (pop) begin
        out_from_skid = 1'b1;
        skid_valid_d  = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        load_out    = 1'b1;
        out_valid_d = 1'b1;
      end else begin
        load_skid    = 1'b1;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (out_from_skid) begin
      out_q <= skid_q;
    end else if (load_out) begin
      out_q <= data_i;
    end
    if (load_skid) begin
      skid_q <= data_i;
    end
  end

  assign ready_o          = !skid_valid_q;
  assign out_o.valid      = out_valid_q;
  assign out_o.next_alive = out_q.next_alive;
  assign out_o.out_row    = out_q.out_row;
  assign out_o.out_col    = out_q.out_col;
  assign out_o.frame_last = out_q.frame_last;

`ifndef ASSERT_OFF
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held while output register empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !skid_valid_q)
    else $error("beat pushed into full buffer");

  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_o.ready))
    else $error("skid filled without output stall");
`endif

endmodule

### dv/life_stencil_checker.sv
module life_stencil_checker #(
  parameter int unsigned MAX_W = lgs_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_H = lgs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  lgs_in_if                              cell_i,
  lgs_out_if                             result_i,
  output int                             fail_count_o,
  output int                             pending_o
);

  // shadow copy of the stencil state
  bit                        row_prev  [MAX_W];
  bit                        row_prev2 [MAX_W];
  logic [lgs_pkg::WIN_W-1:0] nbhd;
  int unsigned               pos_col;
  int unsigned               pos_row;
  int unsigned               grid_w;
  int unsigned               grid_h;

  // next-generation cells still owed by the block, oldest first
  lgs_pkg::result_t          owed_cells [$];
  lgs_pkg::result_t          want;
  lgs_pkg::result_t          seen;

  // advance the raster position by one input beat; returns 1 when a cell is emitted
  function automatic bit next_generation_cell(input logic pad, input logic live,
                                              output lgs_pkg::result_t res);
    int unsigned w, h, c, r, er, ec;
    int          n;
    bit          cur, top, mid, fire, last;
    logic [2:0]  column;
    logic [lgs_pkg::WIN_W-1:0] win;
    w = (grid_w < lgs_pkg::MIN_SIZE) ? lgs_pkg::MIN_SIZE :
        ((grid_w > MAX_W) ? MAX_W : grid_w);
    h = (grid_h < lgs_pkg::MIN_SIZE) ? lgs_pkg::MIN_SIZE :
        ((grid_h > MAX_H) ? MAX_H : grid_h);
    c = pos_col;
    r = pos_row;
    if (c >= w) c = 0;
    if (r > h + 1) r = h + 1;

    // new column of the window; rows above the grid read as dead
    cur    = (!pad && r < h) ? live : 1'b0;
    top    = (r >= 2) ? row_prev2[c] : 1'b0;
    mid    = (r >= 1) ? row_prev[c] : 1'b0;
    column = {cur, mid, top};
    row_prev2[c] = row_prev[c];
    row_prev[c]  = cur;

    if (c == 0) begin
      // closes the last column of an earlier row, dead on the right
      win  = {3'b000, nbhd[8:3]};
      fire = (r >= 2);
      er   = fire ? r - 2 : 0;
      ec   = w - 1;
      nbhd = {column, 6'b000000};
    end else begin
      nbhd = {column, nbhd[8:3]};
      win  = nbhd;
      fire = (r >= 1);
      er   = fire ? r - 1 : 0;
      ec   = c - 1;
    end
    if (er >= h) fire = 1'b0;

    c++;
    if (c == w) begin
      c = 0;
      r++;
    end
    pos_col = c;
    pos_row = r;

    res = '0;
    if (fire) begin
      n    = $countones(win) - int'(win[lgs_pkg::WIN_CENTER]);
      last = (er == h - 1) && (ec == w - 1);
      res.next_alive = (n == lgs_pkg::BIRTH_COUNT) ||
                       (win[lgs_pkg::WIN_CENTER] && n == lgs_pkg::SURVIVE_COUNT);
      res.out_row    = lgs_pkg::POS_W'(er);
      res.out_col    = lgs_pkg::POS_W'(ec);
      res.frame_last = last;
      if (last) begin
        pos_col = 0;
        pos_row = 0;
      end
    end
    return fire;
  endfunction

  initial fail_count_o = 0;
  initial pending_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_W; i++) begin
        row_prev[i]  = 1'b0;
        row_prev2[i] = 1'b0;
      end
      nbhd    = '0;
      pos_col = 0;
      pos_row = 0;
      grid_w  = lgs_pkg::GRID_RESET;
      grid_h  = lgs_pkg::GRID_RESET;
      owed_cells.delete();
      pending_o = 0;
    end else begin
      // register writes restart the raster, spare indexes are ignored
      if (cfg_we_i) begin
        if (cfg_idx_i == lgs_pkg::CFG_GRID_WIDTH) begin
          grid_w  = cfg_wdata_i;
          pos_col = 0;
          pos_row = 0;
        end else if (cfg_idx_i == lgs_pkg::CFG_GRID_HEIGHT) begin
          grid_h  = cfg_wdata_i;
          pos_col = 0;
          pos_row = 0;
        end
      end

      // result beat against the oldest owed cell
      if (result_i.valid && result_i.ready) begin
        seen.next_alive = result_i.next_alive;
        seen.out_row    = result_i.out_row;
        seen.out_col    = result_i.out_col;
        seen.frame_last = result_i.frame_last;
        if (owed_cells.size() == 0) begin
          $error("unexpected result beat: row %0d col %0d next_alive %0d frame_last %0d",
                 seen.out_row, seen.out_col, seen.next_alive, seen.frame_last);
          fail_count_o++;
        end else begin
          want = owed_cells.pop_front();
          if (seen.next_alive !== want.next_alive) begin
            $error("next_alive: expected %0d, actual %0d", want.next_alive, seen.next_alive);
            fail_count_o++;
          end
          if (seen.out_row !== want.out_row) begin
            $error("out_row: expected %0d, actual %0d", want.out_row, seen.out_row);
            fail_count_o++;
          end
          if (seen.out_col !== want.out_col) begin
            $error("out_col: expected %0d, actual %0d", want.out_col, seen.out_col);
            fail_count_o++;
          end
          if (seen.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, actual %0d", want.frame_last, seen.frame_last);
            fail_count_o++;
          end
        end
      end

      // cell beat
      if (cell_i.valid && cell_i.ready) begin
        if (next_generation_cell(cell_i.action, cell_i.alive, want)) begin
          owed_cells.push_back(want);
        end
      end
      pending_o = owed_cells.size();
    end
  end

endmodule

### dv/tb.sv
module tb;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned RANDOM_CELLS  = 800;

  // beat kinds on the cell channel
  localparam logic ACT_CELL  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // register indexes with no register behind them
  localparam logic [lgs_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = lgs_pkg::CFG_IDX_W'(2);
  localparam logic [lgs_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = lgs_pkg::CFG_IDX_W'(3);

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lgs_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                             fail_count;
  int                             pending;
  int unsigned                    cycle_count = 0;
  int unsigned                    cells_sent = 0;
  int unsigned                    eff_w = lgs_pkg::GRID_RESET;
  int unsigned                    eff_h = lgs_pkg::GRID_RESET;
  bit                             in_calm = 1'b0;
  bit                             out_calm = 1'b0;

  lgs_in_if  cell_if ();
  lgs_out_if res_if ();

  life_generation_stencil_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .cell_i      (cell_if),
    .result_o    (res_if)
  );

  life_stencil_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .cell_i       (cell_if),
    .result_i     (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // idle cycles before the next beat, with calm stretches of no idling
  function automatic int unsigned draw_idle(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic int unsigned fit_size(input int unsigned v, input int unsigned hi);
    return (v < lgs_pkg::MIN_SIZE) ? lgs_pkg::MIN_SIZE : ((v > hi) ? hi : v);
  endfunction

  task automatic put_cell(input logic act, input logic live);
    int unsigned gap;
    gap = draw_idle(in_calm);
    if (gap != 0) begin
      cell_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cell_if.valid  <= 1'b1;
    cell_if.action <= act;
    cell_if.alive  <= live;
    do @(posedge clk_i); while (!cell_if.ready);
    cells_sent++;
  endtask

  // wait until every owed cell has come back and the pipeline is quiet
  task automatic settle();
    cell_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lgs_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    if (idx == lgs_pkg::CFG_GRID_WIDTH) eff_w = fit_size(data, lgs_pkg::MAX_WIDTH_DEF);
    if (idx == lgs_pkg::CFG_GRID_HEIGHT) eff_h = fit_size(data, lgs_pkg::MAX_HEIGHT_DEF);
  endtask

  // one generation plus its drain; noisy adds stray padding, drain cell beats and odd drains
  task automatic run_generation(input int unsigned density, input bit noisy,
                                input int unsigned stop_after);
    int unsigned grid_cells, drain, i;
    logic act, live;
    grid_cells = eff_w * eff_h;
    drain = eff_w + 1;
    if (noisy && $urandom_range(0, 3) == 0) drain = $urandom_range(0, eff_w + 3);
    for (i = 0; i < grid_cells + drain; i++) begin
      if (stop_after != 0 && i == stop_after) break;
      if (i < grid_cells) begin
        act  = (noisy && $urandom_range(0, 31) == 0) ? ACT_FLUSH : ACT_CELL;
        live = ($urandom_range(0, 99) < density);
      end else begin
        act  = (noisy && $urandom_range(0, 3) == 0) ? ACT_CELL : ACT_FLUSH;
        live = $urandom_range(0, 1);
      end
      put_cell(act, live);
    end
  endtask

  // result side backpressure
  initial begin : result_drain
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = draw_idle(out_calm);
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_if.valid && res_if.ready));
    end
  end

  initial begin : stimulus
    int unsigned mark, phase, sel, gens, density, stop, i;
    bit noisy;
    rst_ni         <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= '0;
    cfg_wdata      <= '0;
    cell_if.valid  <= 1'b0;
    cell_if.action <= ACT_CELL;
    cell_if.alive  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first rows at the reset grid size
    run_generation(40, 1'b0, 205);
    settle();

    // smallest grid, all alive, a live cell sent as drain
    write_reg(lgs_pkg::CFG_GRID_WIDTH, 8'd3);
    write_reg(lgs_pkg::CFG_GRID_HEIGHT, 8'd3);
    repeat (9) put_cell(ACT_CELL, 1'b1);
    put_cell(ACT_CELL, 1'b1);
    repeat (3) put_cell(ACT_FLUSH, 1'b1);

    // vertical bar with its middle sent as padding, spare writes mid-frame
    for (i = 0; i < 9; i++) begin
      if (i == 4) begin
        settle();
        write_reg(CFG_SPARE_A, 8'hFF);
        write_reg(CFG_SPARE_B, 8'h00);
      end
      put_cell((i == 4) ? ACT_FLUSH : ACT_CELL, (i % 3) == 1);
    end
    repeat (4) put_cell(ACT_FLUSH, 1'b0);

    // random phases, extremes first
    mark  = cells_sent;
    phase = 0;
    while (cells_sent < mark + RANDOM_CELLS) begin
      settle();
      if (phase == 0) begin
        write_reg(lgs_pkg::CFG_GRID_WIDTH, 8'hFF);
        write_reg(lgs_pkg::CFG_GRID_HEIGHT, 8'h00);
      end else if (phase == 1) begin
        write_reg(lgs_pkg::CFG_GRID_HEIGHT, 8'd128);
        write_reg(lgs_pkg::CFG_GRID_WIDTH, 8'd2);
      end else begin
        sel = $urandom_range(0, 15);
        case (sel)
          0: begin
            write_reg(lgs_pkg::CFG_GRID_WIDTH,
                      lgs_pkg::CFG_DATA_W'($urandom_range(128, 255)));
            write_reg(lgs_pkg::CFG_GRID_HEIGHT,
                      lgs_pkg::CFG_DATA_W'($urandom_range(0, 5)));
          end
          1: begin
            write_reg(lgs_pkg::CFG_GRID_HEIGHT,
                      lgs_pkg::CFG_DATA_W'($urandom_range(128, 255)));
            write_reg(lgs_pkg::CFG_GRID_WIDTH,
                      lgs_pkg::CFG_DATA_W'($urandom_range(0, 5)));
          end
          2: begin
            // keep streaming from where the raster stands
          end
          3: write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                       lgs_pkg::CFG_DATA_W'($urandom_range(0, 255)));
          4: write_reg(lgs_pkg::CFG_GRID_WIDTH, lgs_pkg::CFG_DATA_W'($urandom_range(0, 12)));
          default: begin
            if ($urandom_range(0, 1)) begin
              write_reg(lgs_pkg::CFG_GRID_WIDTH,
                        lgs_pkg::CFG_DATA_W'($urandom_range(0, 12)));
              write_reg(lgs_pkg::CFG_GRID_HEIGHT,
                        lgs_pkg::CFG_DATA_W'($urandom_range(0, 12)));
            end else begin
              write_reg(lgs_pkg::CFG_GRID_HEIGHT,
                        lgs_pkg::CFG_DATA_W'($urandom_range(0, 12)));
              write_reg(lgs_pkg::CFG_GRID_WIDTH,
                        lgs_pkg::CFG_DATA_W'($urandom_range(0, 12)));
            end
          end
        endcase
      end

      gens = (eff_w * eff_h > 200) ? 1 : $urandom_range(1, 3);
      for (i = 0; i < gens; i++) begin
        if ($urandom_range(0, 9) == 0) density = 100;
        else if ($urandom_range(0, 9) == 0) density = 0;
        else density = $urandom_range(10, 60);
        noisy = ($urandom_range(0, 3) == 0);
        stop  = (i == gens - 1 && $urandom_range(0, 7) == 0) ?
                $urandom_range(1, eff_w * eff_h) : 0;
        run_generation(density, noisy, stop);
      end
      phase++;
    end

    settle();
    @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
src/lgs_pkg.sv
src/lgs_in_if.sv
src/lgs_out_if.sv
src/lgs_cfg.sv
src/lgs_stencil.sv
src/lgs_out_skid.sv
src/life_generation_stencil_unit.sv
dv/life_stencil_checker.sv
dv/tb.sv
